[hw/rtl/nosc_pkg.sv]
// ----------------------------------------------------------------------------
// nosc_pkg: shared types and constants of the neural oscillator
// Sizes of the hidden layer, the weight word, the accumulator and the codes
// used by the command and configuration ports.
// ----------------------------------------------------------------------------
package nosc_pkg;

    localparam int HIDDEN_UNITS = 512;
    localparam int WEIGHT_BITS  = 16;

    localparam int UNIT_AW   = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
    localparam int UNIT_BITS = 3 * WEIGHT_BITS;

    // datapath widths
    localparam int PROD1_W  = WEIGHT_BITS + 17;
    localparam int PRE_W    = WEIGHT_BITS + 18;
    localparam int RELU_W   = WEIGHT_BITS + 16;
    localparam int TERM_W   = RELU_W + 1 + WEIGHT_BITS;
    localparam int ACC_BASE = (TERM_W + UNIT_AW > 41) ? TERM_W + UNIT_AW : 41;
    localparam int ACC_W    = ACC_BASE + 2;

    localparam logic [16:0] TWO_PI_Q13 = 17'd51472;

    // commands carried in tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_PHASE_STEP  = 2'd0;
    localparam logic [1:0] CFG_AMPLITUDE   = 2'd1;
    localparam logic [1:0] CFG_OUTPUT_BIAS = 2'd2;

    localparam logic [15:0] PHASE_STEP_RST = 16'd472;
    localparam logic [15:0] AMPLITUDE_RST  = 16'd16384;

    typedef logic signed [WEIGHT_BITS-1:0] t_weight;

    typedef struct packed {
        t_weight out_w;
        t_weight hid_b;
        t_weight hid_w;
    } t_unit;

    // tag that travels with each weight word into the MAC pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_mac_ctrl;

    // sign-extend a 16-bit field, then keep WEIGHT_BITS of it
    function automatic t_weight to_weight(input logic [15:0] x);
        logic signed [31:0] s;
        s = 32'(signed'(x));
        return s[WEIGHT_BITS-1:0];
    endfunction

endpackage

[hw/rtl/neural_oscillator_mlp.sv]
// ----------------------------------------------------------------------------
// neural_oscillator_mlp: ReLU-network waveform oscillator
// Loads hidden-unit weights and produces one scaled sample per tick word.
// ----------------------------------------------------------------------------
// A load word (tuser = 0) writes one hidden unit's weights into the weight
// memory; loads to a unit beyond HIDDEN_UNITS are dropped.
// A tick word (tuser = 1) evaluates the network on the current phase; the
// single read port of the weight memory feeds one unit per cycle to the MAC
// pipeline, followed by the pipeline and output scaling stages. The input
// stays not ready for the whole tick; a finished sample waits in the output
// register without holding up the next word. Load every unit before the
// first tick: unloaded weights read as garbage. Write configuration only
// while the block is idle.
module neural_oscillator_mlp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [8:0] unit_index, [24:9] hidden_weight, [40:25] hidden_bias,
    // [56:41] out_weight, [63:57] zero
    input  logic [63:0] i_s_axis_tdata,
    // [0] command
    input  logic [0:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] sample
    output logic [15:0] o_m_axis_tdata,
    // [0] clipped
    output logic [0:0]  o_m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import nosc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [UNIT_AW-1:0]  r_addr, n_addr;
    t_mac_ctrl           r_rd_ctrl, n_rd_ctrl;
    logic [15:0]         r_phase, n_phase;
    logic [15:0]         r_phase_step;
    logic [15:0]         r_amplitude;
    logic signed [15:0]  r_out_bias;

    logic                in_fire, load_fire, tick_fire, last_unit;
    logic                mem_we, mem_re;
    logic [UNIT_AW-1:0]  mem_wr_addr;
    t_unit               mem_wr_data;
    logic [UNIT_BITS-1:0] mem_rd_data;
    logic [16:0]         phase_sum;

    logic                mac_done;
    logic signed [ACC_W-1:0] mac_acc;
    logic                out_done;
    logic [15:0]         out_sample;
    logic                out_clip;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_fire   = i_s_axis_tvalid & o_s_axis_tready;
    assign load_fire = in_fire & (i_s_axis_tuser[0] == CMD_LOAD);
    assign tick_fire = in_fire & (i_s_axis_tuser[0] == CMD_TICK);
    assign last_unit = (r_addr == UNIT_AW'(HIDDEN_UNITS - 1));

    always_comb begin
        mem_we            = load_fire & (32'(i_s_axis_tdata[8:0]) < HIDDEN_UNITS);
        mem_wr_addr       = UNIT_AW'(i_s_axis_tdata[8:0]);
        mem_wr_data.hid_w = to_weight(i_s_axis_tdata[24:9]);
        mem_wr_data.hid_b = to_weight(i_s_axis_tdata[40:25]);
        mem_wr_data.out_w = to_weight(i_s_axis_tdata[56:41]);
        mem_re            = (r_state == ST_RUN);
    end

    // sequencer: sweep every unit once per tick
    always_comb begin
        n_state         = r_state;
        n_addr          = r_addr;
        n_rd_ctrl.valid = 1'b0;
        n_rd_ctrl.last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_addr = '0;
                if (tick_fire) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_rd_ctrl.valid = 1'b1;
                n_rd_ctrl.last  = last_unit;
                if (last_unit) begin
                    n_state = ST_WAIT;
                end else begin
                    n_addr = r_addr + UNIT_AW'(1);
                end
            end
            ST_WAIT: begin
                if (out_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // advance the phase once the sum is complete, wrapping past 2*pi
    always_comb begin
        phase_sum = {1'b0, r_phase} + {1'b0, r_phase_step};
        if (phase_sum > TWO_PI_Q13) begin
            phase_sum = phase_sum - TWO_PI_Q13;
        end
        n_phase = mac_done ? phase_sum[15:0] : r_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_addr       <= '0;
            r_rd_ctrl    <= '0;
            r_phase      <= '0;
            r_phase_step <= PHASE_STEP_RST;
            r_amplitude  <= AMPLITUDE_RST;
            r_out_bias   <= '0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_rd_ctrl <= n_rd_ctrl;
            r_phase   <= n_phase;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PHASE_STEP:  r_phase_step <= i_cfg_data;
                    CFG_AMPLITUDE:   r_amplitude  <= i_cfg_data;
                    CFG_OUTPUT_BIAS: r_out_bias   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    nosc_ram #(
        .WIDTH (UNIT_BITS),
        .DEPTH (HIDDEN_UNITS)
    ) u_wmem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_re      (mem_re),
        .i_rd_addr (r_addr),
        .o_rd_data (mem_rd_data)
    );

    nosc_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (tick_fire),
        .i_out_bias (r_out_bias),
        .i_phase    (r_phase),
        .i_ctrl     (r_rd_ctrl),
        .i_unit     (t_unit'(mem_rd_data)),
        .o_done     (mac_done),
        .o_acc      (mac_acc)
    );

    nosc_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc_valid (mac_done),
        .i_acc       (mac_acc),
        .i_amplitude (r_amplitude),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_sample    (out_sample),
        .o_clip      (out_clip),
        .o_done      (out_done)
    );

    assign o_m_axis_tdata    = out_sample;
    assign o_m_axis_tuser[0] = out_clip;

endmodule

[hw/rtl/nosc_ram.sv]
// ----------------------------------------------------------------------------
// nosc_ram: simple dual-port synchronous RAM
// One write port, one read port with a registered read.
// ----------------------------------------------------------------------------
module nosc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 512
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_wr_addr,
    input  logic [WIDTH-1:0]                              i_wr_data,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]                              o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/nosc_mac.sv]
// ----------------------------------------------------------------------------
// nosc_mac: hidden-layer multiply-accumulate pipeline
// Takes one unit's weights per cycle, forms relu(w1*phase + b1) * w2 and
// sums the terms onto the output bias.
// ----------------------------------------------------------------------------
module nosc_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [15:0]            i_out_bias,
    input  logic [15:0]                   i_phase,
    input  nosc_pkg::t_mac_ctrl           i_ctrl,
    input  nosc_pkg::t_unit               i_unit,
    output logic                          o_done,
    output logic signed [nosc_pkg::ACC_W-1:0] o_acc
);
    import nosc_pkg::*;

    t_mac_ctrl                 r_c1, r_c2, r_c3;
    logic signed [PROD1_W-1:0] r1_prod;
    t_weight                   r1_bias, r1_outw, r2_outw;
    logic [RELU_W-1:0]         r2_relu;
    logic signed [TERM_W-1:0]  r3_term;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_done;
    logic signed [PRE_W-1:0]   pre;

    always_comb begin
        pre = PRE_W'(r1_prod) + (PRE_W'(r1_bias) <<< 13);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1   <= '0;
            r_c2   <= '0;
            r_c3   <= '0;
            r_done <= 1'b0;
        end else begin
            r_c1   <= i_ctrl;
            r_c2   <= r_c1;
            r_c3   <= r_c2;
            r_done <= r_c3.valid & r_c3.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod <= i_unit.hid_w * $signed({1'b0, i_phase});
        r1_bias <= i_unit.hid_b;
        r1_outw <= i_unit.out_w;
        // clear negative pre-activations
        r2_relu <= (pre > 0) ? pre[RELU_W-1:0] : '0;
        r2_outw <= r1_outw;
        r3_term <= $signed({1'b0, r2_relu}) * r2_outw;
        if (i_start) begin
            r_acc <= ACC_W'(i_out_bias) <<< 25;
        end else if (r_c3.valid) begin
            r_acc <= r_acc + ACC_W'(r3_term);
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

[hw/rtl/nosc_out.sv]
// ----------------------------------------------------------------------------
// nosc_out: output scaling and result register
// Rounds the network sum to 32 bits, applies the gain, saturates to Q1.15 and
// holds the word until the downstream side takes it.
// ----------------------------------------------------------------------------
module nosc_out (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_acc_valid,
    input  logic signed [nosc_pkg::ACC_W-1:0] i_acc,
    input  logic [15:0]                       i_amplitude,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [15:0]                       o_sample,
    output logic                              o_clip,
    output logic                              o_done
);
    import nosc_pkg::*;

    localparam int NET_W  = ACC_W - 22;
    localparam int NETX_W = (NET_W > 32) ? NET_W : 32;
    localparam int PROD_W = 49;
    localparam logic signed [31:0] NET_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] NET_MIN = 32'sh8000_0000;

    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [NETX_W-1:0] netx;
    logic signed [31:0]       net_clamp;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [33:0]       scaled;
    logic                     move;

    logic                     r_a_valid, r_b_valid, r_out_valid;
    logic signed [31:0]       r_a_net;
    logic signed [PROD_W-1:0] r_b_prod;
    logic [15:0]              r_sample;
    logic                     r_clip;

    always_comb begin
        acc_rnd = i_acc + (ACC_W'(1) <<< 21);
        netx    = NETX_W'($signed(acc_rnd[ACC_W-1:22]));
        // beyond 32 bits any nonzero gain saturates anyway
        if (netx > NETX_W'(NET_MAX)) begin
            net_clamp = NET_MAX;
        end else if (netx < NETX_W'(NET_MIN)) begin
            net_clamp = NET_MIN;
        end else begin
            net_clamp = netx[31:0];
        end
        prod_rnd = r_b_prod + PROD_W'(16384);
        scaled   = prod_rnd[PROD_W-1:15];
        move     = r_b_valid & (~r_out_valid | i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_valid <= i_acc_valid;
            if (r_a_valid) begin
                r_b_valid <= 1'b1;
            end else if (move) begin
                r_b_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc_valid) begin
            r_a_net <= net_clamp;
        end
        if (r_a_valid) begin
            r_b_prod <= r_a_net * $signed({1'b0, i_amplitude});
        end
        if (move) begin
            if (scaled > 34'sd32767) begin
                r_sample <= 16'h7FFF;
                r_clip   <= 1'b1;
            end else if (scaled < -34'sd32768) begin
                r_sample <= 16'h8000;
                r_clip   <= 1'b1;
            end else begin
                r_sample <= scaled[15:0];
                r_clip   <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_sample   = r_sample;
    assign o_clip     = r_clip;
    assign o_done     = move;

endmodule

[hw/rtl/nosc_check.sv]
// ----------------------------------------------------------------------------
// nosc_check: port-level checks for the neural oscillator
// Watches the stream ports over time and binds to the top level.
// ----------------------------------------------------------------------------
module nosc_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [0:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);
    // no word may leave right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // a tick occupies the engine, so the input must close
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0] |=> !o_s_axis_tready)
        else $error("input still ready after a tick word");

    // a load leaves the input open
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser[0] |=> o_s_axis_tready)
        else $error("input closed after a load word");

    // a clipped sample sits at full scale
    a_clip_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0]
            |-> (o_m_axis_tdata == 16'h7FFF) || (o_m_axis_tdata == 16'h8000))
        else $error("clipped flag on a sample below full scale");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
            |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled output word changed");

endmodule

bind neural_oscillator_mlp nosc_check u_nosc_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
